[rtl/core/kar_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package kar_pkg;

    // Bank size and field widths
    localparam int NUM_CONTROLS = 12;
    localparam int IDX_W        = 4;
    localparam int TIME_W       = 32;
    localparam int CFG_W        = 16;

    // Register reset values
    localparam logic [CFG_W-1:0] DELAY_RESET    = 16'd500;
    localparam logic [CFG_W-1:0] INTERVAL_RESET = 16'd30;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_DELAY    = 2'd0;
    localparam logic [1:0] REG_INTERVAL = 2'd1;
    localparam logic [1:0] REG_EVENTS   = 2'd2;

    typedef enum logic [1:0] {
        KIND_DOWN    = 2'd0,
        KIND_UP      = 2'd1,
        KIND_SUMMARY = 2'd2
    } kind_t;

    typedef struct packed {
        logic [NUM_CONTROLS-1:0] held_mask;
        logic [TIME_W-1:0]       now_ms;
    } in_item_t;

    typedef struct packed {
        kind_t                   kind;
        logic [IDX_W-1:0]        control_index;
        logic [NUM_CONTROLS-1:0] triggered_mask;
        logic                    last;
    } out_item_t;

    typedef struct packed {
        logic [CFG_W-1:0] delay_ms;
        logic [CFG_W-1:0] interval_ms;
        logic             events_enabled;
    } cfg_t;

    // What one lane found for the accepted update
    typedef struct packed {
        logic fire;
        logic released;
    } lane_evt_t;

    // Status of the merge stage seen by the top level
    typedef struct packed {
        logic job_valid;
        logic finish;
    } merge_stat_t;

endpackage

`default_nettype wire

[rtl/core/kar_lane.sv]
`timescale 1ns / 1ps
`default_nettype none

module kar_lane
    import kar_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              accept,
    input  wire logic              is_dn,
    input  wire logic              was_dn,
    input  wire logic [TIME_W-1:0] now_ms,
    input  wire cfg_t              cfg,
    output lane_evt_t              evt
);

    logic [TIME_W-1:0] deadline_reg;
    logic [TIME_W-1:0] deadline_next;
    logic              press;
    logic              repeat_due;

    // Classify this control for the current update
    always_comb begin
        press      = is_dn && !was_dn;
        repeat_due = is_dn && was_dn && (now_ms > deadline_reg);
        evt.fire     = press || repeat_due;
        evt.released = !is_dn && was_dn;
    end

    // Arm on a new press, advance on a repeat
    always_comb begin
        deadline_next = deadline_reg;
        if (press) begin
            deadline_next = now_ms + {{(TIME_W-CFG_W){1'b0}}, cfg.delay_ms};
        end else if (repeat_due) begin
            deadline_next = deadline_reg + {{(TIME_W-CFG_W){1'b0}}, cfg.interval_ms};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deadline_reg <= '0;
        end else if (accept) begin
            deadline_reg <= deadline_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/kar_merge.sv]
`timescale 1ns / 1ps
`default_nettype none

module kar_merge
    import kar_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    load,
    input  wire logic [NUM_CONTROLS-1:0] ev_mask,
    input  wire logic [NUM_CONTROLS-1:0] up_mask,
    input  wire logic [NUM_CONTROLS-1:0] trig_mask,
    output logic                         ready,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output out_item_t                    m_data,
    output merge_stat_t                  stat
);

    logic                    job_valid_reg;
    logic [NUM_CONTROLS-1:0] ev_reg;
    logic [NUM_CONTROLS-1:0] up_reg;
    logic [NUM_CONTROLS-1:0] trig_reg;
    logic                    m_valid_reg;
    out_item_t               m_data_reg;

    logic                    out_free;
    logic                    has_ev;
    logic                    step;
    logic                    finish;
    logic [NUM_CONTROLS-1:0] lowest;
    logic [IDX_W-1:0]        lowest_idx;
    out_item_t               item_next;

    // Isolate and encode the lowest pending control
    always_comb begin
        lowest     = ev_reg & (~ev_reg + {{(NUM_CONTROLS-1){1'b0}}, 1'b1});
        lowest_idx = '0;
        for (int i = 0; i < NUM_CONTROLS; i++) begin
            if (lowest[i]) begin
                lowest_idx = lowest_idx | IDX_W'(i);
            end
        end
    end

    // Pick the next item: an event in control order, else the summary
    always_comb begin
        out_free = !m_valid_reg || m_ready;
        has_ev   = |ev_reg;
        step     = job_valid_reg && out_free;
        finish   = step && !has_ev;
        ready    = !job_valid_reg || finish;
        if (has_ev) begin
            item_next.kind           = ((up_reg & lowest) != '0) ? KIND_UP : KIND_DOWN;
            item_next.control_index  = lowest_idx;
            item_next.triggered_mask = '0;
            item_next.last           = 1'b0;
        end else begin
            item_next.kind           = KIND_SUMMARY;
            item_next.control_index  = '0;
            item_next.triggered_mask = trig_reg;
            item_next.last           = 1'b1;
        end
    end

    // Hold the job and the output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (out_free) begin
                m_valid_reg <= step;
            end
            if (step) begin
                m_data_reg <= item_next;
            end
            if (load) begin
                job_valid_reg <= 1'b1;
                ev_reg        <= ev_mask;
                up_reg        <= up_mask;
                trig_reg      <= trig_mask;
            end else begin
                if (finish) begin
                    job_valid_reg <= 1'b0;
                end
                if (step) begin
                    ev_reg <= ev_reg & ~lowest;
                end
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_data         = m_data_reg;
    assign stat.job_valid = job_valid_reg;
    assign stat.finish    = finish;

endmodule

`default_nettype wire

[rtl/core/key_auto_repeat.sv]
// Channel   Direction  Handshake           Payload
// s_        in         s_valid / s_ready   in_item_t  (held_mask, now_ms)
// m_        out        m_valid / m_ready   out_item_t (kind, control_index, triggered_mask, last)
// apb       in         psel/penable/pready registers at 0x0, 0x4, 0x8
//
// An update is classified in the lanes, then yields E event items and a summary (E is the number
// of down/up events, 0..12); the output register emits one item a cycle unless m_ready stalls.
// The next update is accepted in the cycle its predecessor's summary is loaded out.
// Reset (aresetn low, synchronous) clears deadlines, previous mask and pending job.
// A stalled m_ready holds the output item and, while a job is pending, keeps s_ready low.
`timescale 1ns / 1ps
`default_nettype none

module key_auto_repeat
    import kar_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire in_item_t    s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_item_t        m_data,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    cfg_t                    cfg_reg;
    logic [NUM_CONTROLS-1:0] prev_held_reg;
    logic                    accept;
    logic                    cfg_wr;
    lane_evt_t               lane_evt [NUM_CONTROLS];
    logic [NUM_CONTROLS-1:0] fire_mask;
    logic [NUM_CONTROLS-1:0] up_mask;
    logic [NUM_CONTROLS-1:0] ev_mask;
    merge_stat_t             stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign accept = s_valid && s_ready;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.delay_ms       <= DELAY_RESET;
            cfg_reg.interval_ms    <= INTERVAL_RESET;
            cfg_reg.events_enabled <= 1'b1;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_DELAY:    cfg_reg.delay_ms       <= pwdata[CFG_W-1:0];
                REG_INTERVAL: cfg_reg.interval_ms    <= pwdata[CFG_W-1:0];
                REG_EVENTS:   cfg_reg.events_enabled <= pwdata[0];
                default:      ;
            endcase
        end
    end

    // Read back configuration
    always_comb begin
        unique case (paddr[3:2])
            REG_DELAY:    prdata = {{(32-CFG_W){1'b0}}, cfg_reg.delay_ms};
            REG_INTERVAL: prdata = {{(32-CFG_W){1'b0}}, cfg_reg.interval_ms};
            REG_EVENTS:   prdata = {31'd0, cfg_reg.events_enabled};
            default:      prdata = '0;
        endcase
    end

    // Remember the held mask of the last accepted update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_held_reg <= '0;
        end else if (accept) begin
            prev_held_reg <= s_data.held_mask;
        end
    end

    // One lane per control
    for (genvar g = 0; g < NUM_CONTROLS; g++) begin : g_lane
        kar_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .accept  (accept),
            .is_dn   (s_data.held_mask[g]),
            .was_dn  (prev_held_reg[g]),
            .now_ms  (s_data.now_ms),
            .cfg     (cfg_reg),
            .evt     (lane_evt[g])
        );
        assign fire_mask[g] = lane_evt[g].fire;
        assign up_mask[g]   = lane_evt[g].released;
    end

    // Drop per-control events when they are disabled
    assign ev_mask = cfg_reg.events_enabled ? (fire_mask | up_mask) : '0;

    kar_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (accept),
        .ev_mask   (ev_mask),
        .up_mask   (up_mask),
        .trig_mask (fire_mask),
        .ready     (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .stat      (stat)
    );

`ifndef NO_ASSERTIONS
    a_last_is_summary: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.last == (m_data.kind == KIND_SUMMARY)))
        else $error("last flag does not match summary item");

    a_event_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.kind != KIND_SUMMARY) |->
            (m_data.triggered_mask == '0 && m_data.control_index < IDX_W'(NUM_CONTROLS)))
        else $error("event item carries bad fields");

    a_load_job: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> stat.job_valid)
        else $error("accepted item did not start a job");

    a_accept_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |-> (!stat.job_valid || stat.finish))
        else $error("item accepted while a job is still draining");
`endif

endmodule

`default_nettype wire
